@@ hw/rtl/sstf_pkg.sv @@
// Shared constants and types for the SSTF disk scheduler.
package sstf_pkg;

	localparam int SSTF_MAX_REQ   = 32;
	localparam int SSTF_CYL_BITS  = 16;
	localparam int SSTF_FIELD_W   = 16;
	localparam int SSTF_SUM_W     = 21;
	localparam int SSTF_OUT_W     = 56;
	localparam logic [SSTF_SUM_W-1:0] SSTF_SUM_MAX = {SSTF_SUM_W{1'b1}};

	typedef struct packed {
		logic wr;
		logic mark;
		logic clear;
	} cell_ctrl_t;

	typedef struct packed {
		logic valid;
		logic found;
	} tok_flags_t;

endpackage

@@ hw/rtl/sstf_cell.sv @@
// One request slot of the scheduler chain: stores a cylinder and folds it into the passing search word.
module sstf_cell #(
	parameter int IDX = 0,
	parameter int CW  = 16,
	parameter int IW  = 5,
	parameter int NW  = 6
) (
	input  logic                clk,
	input  logic                arst_n,
	input  sstf_pkg::cell_ctrl_t ctrl,
	input  logic [IW-1:0]       wr_idx,
	input  logic [CW-1:0]       wr_cyl,
	input  logic [IW-1:0]       mark_idx,
	input  logic [NW-1:0]       count,
	input  logic [CW-1:0]       head,
	input  sstf_pkg::tok_flags_t tin,
	input  logic [CW-1:0]       tin_dist,
	input  logic [CW-1:0]       tin_cyl,
	input  logic [IW-1:0]       tin_idx,
	output sstf_pkg::tok_flags_t tout,
	output logic [CW-1:0]       tout_dist,
	output logic [CW-1:0]       tout_cyl,
	output logic [IW-1:0]       tout_idx
);
	import sstf_pkg::*;

	logic [CW-1:0] cyl_q;
	logic          served_q;
	logic          occupied;
	logic          cand;
	logic          take;
	logic [CW-1:0] seek_d;
	tok_flags_t    flags_q;
	logic [CW-1:0] dist_q;
	logic [CW-1:0] bcyl_q;
	logic [IW-1:0] idx_q;

	assign occupied = NW'(IDX) < count;
	assign cand     = occupied & ~served_q;
	assign seek_d   = (head >= cyl_q) ? (head - cyl_q) : (cyl_q - head);
	assign take     = tin.valid & cand & (~tin.found | (seek_d < tin_dist));

	always_ff @(posedge clk) begin
		if (ctrl.wr && wr_idx == IW'(IDX)) begin
			cyl_q <= wr_cyl;
		end
		dist_q <= take ? seek_d : tin_dist;
		bcyl_q <= take ? cyl_q : tin_cyl;
		idx_q  <= take ? IW'(IDX) : tin_idx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			served_q <= 1'b0;
			flags_q  <= '0;
		end else begin
			if (ctrl.clear) begin
				served_q <= 1'b0;
			end else if (ctrl.mark && mark_idx == IW'(IDX)) begin
				served_q <= 1'b1;
			end else if (ctrl.wr && wr_idx == IW'(IDX)) begin
				served_q <= 1'b0;
			end
			flags_q.valid <= tin.valid;
			flags_q.found <= tin.valid & (tin.found | cand);
		end
	end

	assign tout      = flags_q;
	assign tout_dist = dist_q;
	assign tout_cyl  = bcyl_q;
	assign tout_idx  = idx_q;

endmodule

@@ hw/rtl/sstf_disk_scheduler_core.sv @@
// Top level of the SSTF disk scheduler: load control, search chain and result register.
// Loading takes one request word per cycle; tready is high whenever no batch is being served.
// After the word marked tlast, each result is found in steps: the start register launches a
// search word, it walks the full chain of MAX_REQUESTS cells, the pick is captured, then the
// emit state commits it to the output register. A stalled output holds the next pick.
// Asynchronous active-low reset empties the batch, clears served marks, head, sum and flags.
module sstf_disk_scheduler_core #(
	parameter int MAX_REQUESTS  = sstf_pkg::SSTF_MAX_REQ,
	parameter int CYLINDER_BITS = sstf_pkg::SSTF_CYL_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data,    // initial_head
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,     // [15:0] cylinder
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [sstf_pkg::SSTF_OUT_W-1:0] m_tdata, // [15:0] served_cylinder,
	                                  // [31:16] seek_distance, [52:32] total_movement,
	                                  // [53] overflowed, [55:54] zero
	output logic        m_tlast
);
	import sstf_pkg::*;

	localparam int CW = CYLINDER_BITS;
	localparam int IW = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
	localparam int NW = $clog2(MAX_REQUESTS + 1);
	localparam int AW = ((CW > SSTF_SUM_W) ? CW : SSTF_SUM_W) + 1;
	localparam int FW = SSTF_FIELD_W;

	typedef enum logic [2:0] {
		S_LOAD = 3'b001,
		S_SCAN = 3'b010,
		S_EMIT = 3'b100
	} state_t;

	state_t              state_q;
	logic [15:0]         init_q;
	logic [NW-1:0]       count_q;
	logic [NW-1:0]       rem_q;
	logic [CW-1:0]       head_q;
	logic [SSTF_SUM_W-1:0] sum_q;
	logic                drop_q;
	logic                start_q;
	logic [CW-1:0]       best_cyl_q;
	logic [CW-1:0]       best_dist_q;
	logic [IW-1:0]       best_idx_q;

	logic                out_valid_q;
	logic [FW-1:0]       out_cyl_q;
	logic [FW-1:0]       out_dist_q;
	logic [SSTF_SUM_W-1:0] out_sum_q;
	logic                out_ovf_q;
	logic                out_last_q;

	cell_ctrl_t          ctrl;
	logic                in_acc;
	logic                has_room;
	logic [NW-1:0]       count_nx;
	logic                out_free;
	logic                commit;
	logic [31:0]         cin_ext;
	logic [31:0]         init_ext;
	logic [CW-1:0]       cin;
	logic [AW-1:0]       sum_ext;
	logic [SSTF_SUM_W-1:0] sum_nx;
	logic [31:0]         bcyl_ext;
	logic [31:0]         bdist_ext;

	tok_flags_t          tf [0:MAX_REQUESTS];
	logic [CW-1:0]       td [0:MAX_REQUESTS];
	logic [CW-1:0]       tc [0:MAX_REQUESTS];
	logic [IW-1:0]       ti [0:MAX_REQUESTS];

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == S_LOAD);
	assign in_acc    = s_tvalid & s_tready;
	assign has_room  = count_q < NW'(MAX_REQUESTS);
	assign count_nx  = has_room ? count_q + NW'(1) : count_q;
	assign out_free  = ~out_valid_q | m_tready;
	assign commit    = (state_q == S_EMIT) & out_free;

	assign cin_ext  = 32'(s_tdata);
	assign cin      = cin_ext[CW-1:0];
	assign init_ext = 32'(init_q);

	assign sum_ext = AW'(sum_q) + AW'(best_dist_q);
	assign sum_nx  = (sum_ext > AW'(SSTF_SUM_MAX)) ? SSTF_SUM_MAX : sum_ext[SSTF_SUM_W-1:0];
	assign bcyl_ext  = 32'(best_cyl_q);
	assign bdist_ext = 32'(best_dist_q);

	assign ctrl.wr    = in_acc & has_room;
	assign ctrl.mark  = commit;
	assign ctrl.clear = commit & (rem_q == NW'(1));

	assign tf[0].valid = start_q;
	assign tf[0].found = 1'b0;
	assign td[0] = '0;
	assign tc[0] = '0;
	assign ti[0] = '0;

	for (genvar g = 0; g < MAX_REQUESTS; g++) begin : g_cell
		sstf_cell #(
			.IDX(g),
			.CW (CW),
			.IW (IW),
			.NW (NW)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl),
			.wr_idx   (count_q[IW-1:0]),
			.wr_cyl   (cin),
			.mark_idx (best_idx_q),
			.count    (count_q),
			.head     (head_q),
			.tin      (tf[g]),
			.tin_dist (td[g]),
			.tin_cyl  (tc[g]),
			.tin_idx  (ti[g]),
			.tout     (tf[g+1]),
			.tout_dist(td[g+1]),
			.tout_cyl (tc[g+1]),
			.tout_idx (ti[g+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_LOAD;
			init_q      <= '0;
			count_q     <= '0;
			rem_q       <= '0;
			head_q      <= '0;
			sum_q       <= '0;
			drop_q      <= 1'b0;
			start_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			start_q <= (in_acc & s_tlast) | (commit & (rem_q != NW'(1)));
			if (cfg_valid) begin
				init_q <= cfg_data;
			end
			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_LOAD: begin
					if (in_acc) begin
						count_q <= count_nx;
						if (!has_room) begin
							drop_q <= 1'b1;
						end
						if (s_tlast) begin
							rem_q   <= count_nx;
							head_q  <= init_ext[CW-1:0];
							sum_q   <= '0;
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (tf[MAX_REQUESTS].valid) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						head_q <= best_cyl_q;
						rem_q  <= rem_q - NW'(1);
						if (rem_q == NW'(1)) begin
							count_q <= '0;
							drop_q  <= 1'b0;
							sum_q   <= '0;
							state_q <= S_LOAD;
						end else begin
							sum_q   <= sum_nx;
							state_q <= S_SCAN;
						end
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_SCAN && tf[MAX_REQUESTS].valid) begin
			best_cyl_q  <= tc[MAX_REQUESTS];
			best_dist_q <= td[MAX_REQUESTS];
			best_idx_q  <= ti[MAX_REQUESTS];
		end
		if (commit) begin
			out_cyl_q  <= bcyl_ext[FW-1:0];
			out_dist_q <= bdist_ext[FW-1:0];
			out_sum_q  <= sum_nx;
			out_ovf_q  <= (rem_q == NW'(1)) & drop_q;
			out_last_q <= (rem_q == NW'(1));
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, out_ovf_q, out_sum_q, out_dist_q, out_cyl_q};
	assign m_tlast  = out_last_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= NW'(MAX_REQUESTS))
		else $error("request count beyond capacity");

	a_wave_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		tf[MAX_REQUESTS].valid |-> (state_q == S_SCAN) && tf[MAX_REQUESTS].found)
		else $error("search word left the chain outside a scan or without a pick");

	a_batch_done: assert property (@(posedge clk) disable iff (!arst_n)
		(commit && rem_q == NW'(1)) |=> (state_q == S_LOAD) && (count_q == '0) && !drop_q)
		else $error("batch not cleared after its final pick");

	a_sum_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(commit && rem_q != NW'(1)) |=> sum_q >= $past(sum_q))
		else $error("running movement decreased within a batch");

endmodule

@@ tb/sv/testbench.sv @@
// Self-checking testbench for sstf_disk_scheduler_core: stream driver, predictor and checker.
module testbench;
	import sstf_pkg::*;

	localparam int CYCLE_LIMIT  = 300000;
	localparam int DRAIN_CYCLES = 2 * SSTF_MAX_REQ + 8;
	localparam int RANDOM_WORDS = 150;
	localparam int LONG_HOLD    = 400;

	typedef struct packed {
		logic [15:0] cyl;
		logic        batch_end;
	} request_t;

	typedef struct packed {
		logic [15:0]           cyl;
		logic [15:0]           seek;
		logic [SSTF_SUM_W-1:0] total;
		logic                  ovf;
		logic                  last;
	} pick_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [15:0] cfg_data = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [15:0] s_tdata = '0;
	logic s_tlast = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [SSTF_OUT_W-1:0] m_tdata;
	logic m_tlast;

	request_t req_pending[$];
	pick_t sched_picks[$];

	logic [15:0] start_head = '0;
	logic [15:0] stored_cyl[SSTF_MAX_REQ];
	int stored_count = 0;
	bit drop_seen = 1'b0;

	int words_queued = 0;
	int words_accepted = 0;
	int fail_count = 0;
	int cycle_count = 0;
	bit calm = 1'b0;
	bit hold_arm = 1'b0;

	sstf_disk_scheduler_core u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("sstf_disk_scheduler_core test failed");
			$finish;
		end
	end

	// stores one request; on the batch end, works out the whole service order
	function automatic void schedule_request(input logic [15:0] cyl, input logic batch_end);
		logic [15:0] head;
		logic [15:0] best;
		logic [15:0] seek_d;
		logic [SSTF_SUM_W:0] sum;
		logic [SSTF_MAX_REQ-1:0] done;
		int pick;
		bit found;
		pick_t p;
		if (stored_count < SSTF_MAX_REQ) begin
			stored_cyl[stored_count] = cyl;
			stored_count++;
		end else begin
			drop_seen = 1'b1;
		end
		if (!batch_end)
			return;
		head = start_head;
		sum = '0;
		done = '0;
		for (int k = 0; k < stored_count; k++) begin
			found = 1'b0;
			pick = 0;
			best = '0;
			for (int i = 0; i < stored_count; i++) begin
				if (!done[i]) begin
					seek_d = (head >= stored_cyl[i]) ? head - stored_cyl[i]
						: stored_cyl[i] - head;
					if (!found || seek_d < best) begin
						best = seek_d;
						pick = i;
						found = 1'b1;
					end
				end
			end
			done[pick] = 1'b1;
			head = stored_cyl[pick];
			sum = sum + best;
			if (sum > SSTF_SUM_MAX)
				sum = {1'b0, SSTF_SUM_MAX};
			p.cyl = head;
			p.seek = best;
			p.total = sum[SSTF_SUM_W-1:0];
			p.last = (k == stored_count - 1);
			p.ovf = p.last && drop_seen;
			sched_picks.push_back(p);
		end
		stored_count = 0;
		drop_seen = 1'b0;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	task automatic check_field(input string what, input logic [SSTF_SUM_W-1:0] want_v,
			input logic [SSTF_SUM_W-1:0] got_v);
		if (got_v !== want_v) begin
			$display("%0t: %s mismatch, expected %0d actual %0d", $time, what, want_v, got_v);
			fail_count++;
		end
	endtask

	// request driver
	always @(posedge clk) begin
		request_t nxt;
		int gap_left;
		if (s_tvalid && s_tready) begin
			words_accepted++;
			schedule_request(s_tdata, s_tlast);
		end
		if (!s_tvalid || s_tready) begin
			if (gap_left > 0) begin
				gap_left--;
				s_tvalid <= 1'b0;
			end else if (req_pending.size() != 0) begin
				nxt = req_pending.pop_front();
				s_tdata <= nxt.cyl;
				s_tlast <= nxt.batch_end;
				s_tvalid <= 1'b1;
				gap_left = pick_gap();
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// result monitor and receiver back-pressure
	always @(posedge clk) begin
		pick_t want;
		int stall_left;
		int hold_left;
		bit hold_taken;
		if (m_tvalid && m_tready) begin
			if (sched_picks.size() == 0) begin
				$display("%0t: unexpected result word, expected none actual %h last %b",
					$time, m_tdata, m_tlast);
				fail_count++;
			end else begin
				want = sched_picks.pop_front();
				check_field("served_cylinder", SSTF_SUM_W'(want.cyl),
					SSTF_SUM_W'(m_tdata[15:0]));
				check_field("seek_distance", SSTF_SUM_W'(want.seek),
					SSTF_SUM_W'(m_tdata[31:16]));
				check_field("total_movement", want.total, m_tdata[52:32]);
				check_field("overflowed", SSTF_SUM_W'(want.ovf), SSTF_SUM_W'(m_tdata[53]));
				check_field("pad bits", '0, SSTF_SUM_W'(m_tdata[55:54]));
				check_field("last", SSTF_SUM_W'(want.last), SSTF_SUM_W'(m_tlast));
			end
		end
		if (hold_arm && !hold_taken) begin
			hold_taken = 1'b1;
			hold_left = LONG_HOLD;
			m_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
			if (!calm && $urandom_range(0, 4) == 0)
				stall_left = pick_gap();
		end
	end

	task automatic add_request(input logic [15:0] cyl, input logic batch_end);
		request_t r;
		r.cyl = cyl;
		r.batch_end = batch_end;
		req_pending.push_back(r);
		words_queued++;
	endtask

	task automatic wait_drained();
		while (words_accepted != words_queued || sched_picks.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_start_head(input logic [15:0] cyl);
		cfg_data <= cyl;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		start_head = cyl;
	endtask

	function automatic logic [15:0] draw_cylinder(input int mode);
		logic [15:0] c;
		case (mode)
			0: c = 16'($urandom_range(0, 65535));
			1: c = 16'(32'(start_head) + $urandom_range(0, 16) - 8);
			2: begin
				case ($urandom_range(0, 3))
					0: c = 16'h0000;
					1: c = 16'hFFFF;
					2: c = 16'h8000;
					default: c = start_head;
				endcase
			end
			default: c = 16'($urandom_range(0, 15));
		endcase
		return c;
	endfunction

	function automatic int batch_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return $urandom_range(1, 6);
		if (r < 88)
			return $urandom_range(7, 31);
		if (r < 94)
			return SSTF_MAX_REQ;
		return $urandom_range(SSTF_MAX_REQ + 1, SSTF_MAX_REQ + 4);
	endfunction

	task automatic queue_batch(input int len);
		int mode;
		mode = $urandom_range(0, 3);
		for (int i = 0; i < len; i++)
			add_request(draw_cylinder(mode), i == len - 1);
	endtask

	initial begin
		int random_words;
		int phase_words;
		int phase;
		int len;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: zero and full-range seeks, duplicates
		set_start_head(16'h0000);
		add_request(16'h0000, 1'b1);
		add_request(16'hFFFF, 1'b1);
		add_request(16'hFFFF, 1'b0);
		add_request(16'h0000, 1'b0);
		add_request(16'h8000, 1'b1);
		add_request(16'h0007, 1'b0);
		add_request(16'h0007, 1'b1);
		wait_drained();

		// directed: near-equal distances, ties to the earliest word, alternating bits
		set_start_head(16'h8000);
		add_request(16'hFFFF, 1'b0);
		add_request(16'h0000, 1'b1);
		add_request(16'h7FF0, 1'b0);
		add_request(16'h8010, 1'b0);
		add_request(16'h8010, 1'b0);
		add_request(16'h7FF0, 1'b1);
		add_request(16'hAAAA, 1'b0);
		add_request(16'h5555, 1'b1);
		wait_drained();

		// store full: extra words dropped, batch end on a dropped word
		set_start_head(16'h1234);
		queue_batch(SSTF_MAX_REQ + 2);
		random_words = SSTF_MAX_REQ + 2;
		wait_drained();

		phase = 0;
		while (random_words < RANDOM_WORDS) begin
			case (phase % 4)
				0: set_start_head(16'hFFFF);
				1: set_start_head(16'h0000);
				2: set_start_head(16'($urandom_range(0, 65535)));
				default: set_start_head(16'h8000);
			endcase
			calm = (phase % 3 == 2);
			// receiver holds off while several batches are offered
			if (phase == 1)
				hold_arm = 1'b1;
			phase_words = 0;
			while (phase_words < 24) begin
				len = batch_len();
				queue_batch(len);
				phase_words += len;
			end
			random_words += phase_words;
			phase++;
			wait_drained();
		end

		if (fail_count == 0)
			$display("sstf_disk_scheduler_core test passed");
		else
			$display("sstf_disk_scheduler_core test failed");
		$finish;
	end

endmodule

@@ filelist.f @@
hw/rtl/sstf_pkg.sv
hw/rtl/sstf_cell.sv
hw/rtl/sstf_disk_scheduler_core.sv
tb/sv/testbench.sv
